/* hw/rtl/assert_macros.svh */
// Assertion macros of the packet dedup window RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define PDW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pdw assertion failed");

// Next-cycle implication, disabled while reset is low.
`define PDW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pdw assertion failed");

`endif

/* hw/rtl/pdw_pkg.sv */
// Types and constants of the packet dedup window.
`timescale 1ns / 1ps
`default_nettype none
package pdw_pkg;

    localparam int unsigned ID_W    = 32;
    localparam int unsigned STAMP_W = 32;
    localparam int unsigned COUNT_W = 6;

    localparam logic KIND_CHECK = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [STAMP_W-1:0] EXPIRY_RESET = 32'd30000;

    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [ID_W-1:0]    pkt_id;
    } t_entry;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;

endpackage
`default_nettype wire

/* hw/rtl/pdw_cell.sv */
// One storage cell of the id chain: load, shift from the upper neighbor, or hold.
`timescale 1ns / 1ps
`default_nettype none
module pdw_cell (
    input  wire logic              i_clk,
    input  wire pdw_pkg::t_cell_ctl i_ctl,
    input  wire pdw_pkg::t_entry   i_nbr,
    input  wire pdw_pkg::t_entry   i_load_data,
    output pdw_pkg::t_entry        o_entry
);

    pdw_pkg::t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_entry <= i_load_data;
        end else if (i_ctl.shift) begin
            r_entry <= i_nbr;
        end
    end

    assign o_entry = r_entry;

endmodule
`default_nettype wire

/* hw/rtl/packet_dedup_window_unit.sv */
// Top level of the packet dedup window: cell chain, scan sequencer and result register.
//
// Slave channel carries one item per transfer: tuser is the kind (check or
// query), tdata holds the packet id and the current time. Master channel
// returns one result per item: the hit flag and the entry count after it.
// i_cfg_we with i_cfg_wdata writes the expiry time; write it only while idle.
//
// An item is taken only in the idle state. The stored entries then stream
// through cell 0 of the chain, one per cycle, and each is judged there:
// survivors are written back at the tail of the kept run, so the list is
// compacted in order. The update state then appends or evicts for a new
// id and loads the result. No new item is taken until that result is
// loaded; the one-at-a-time walk through the chain head sets how long
// an item occupies the block.
// A new item may be taken while a result waits in the output register; the
// following result waits in the update state until the receiver takes it.
// Synchronous reset empties the list and restores the expiry to 30000.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module packet_dedup_window_unit #(
    parameter int unsigned ENTRIES = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [63:0] i_s_tdata,   // [31:0] pkt_id, [63:32] time_now
    input  wire logic        i_s_tuser,   // [0] kind
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata    // [0] hit, [6:1] entry_count, [7] zero
);

    import pdw_pkg::*;

    localparam int unsigned IW = $clog2(ENTRIES);
    localparam int unsigned CW = $clog2(ENTRIES + 1);

    t_state               r_state, n_state;
    logic [CW-1:0]        r_cnt;
    logic [CW-1:0]        r_left;
    logic [CW-1:0]        r_ptr;
    logic [CW-1:0]        r_kept;
    logic [STAMP_W-1:0]   r_min_stamp;
    logic [IW-1:0]        r_min_idx;
    logic                 r_hit;
    logic                 r_kind;
    logic [ID_W-1:0]      r_id;
    logic [STAMP_W-1:0]   r_now;
    logic [STAMP_W-1:0]   r_expiry;
    logic                 r_ovalid;
    logic                 r_ohit;
    logic [COUNT_W-1:0]   r_ocount;

    t_entry               w_entry [ENTRIES];
    t_cell_ctl            w_ctl   [ENTRIES];
    t_entry               w_head;
    t_entry               w_ld_data;
    logic                 w_scan;
    logic                 w_ld_en;
    logic [IW-1:0]        w_ld_idx;
    logic [STAMP_W-1:0]   w_age;
    logic                 w_live;
    logic                 w_match;
    logic                 w_keep;
    logic                 w_slot_free;
    logic                 w_s_acc;
    logic                 w_add;
    logic [CW-1:0]        w_ptr_dec;
    logic [CW-1:0]        w_new_cnt;
    logic [CW+5:0]        w_cnt_ext;

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
            t_entry w_nbr;
            if (gi == ENTRIES - 1) begin : g_tail
                assign w_nbr = w_entry[gi];
            end else begin : g_body
                assign w_nbr = w_entry[gi+1];
            end
            assign w_ctl[gi].shift = w_scan;
            assign w_ctl[gi].load  = w_ld_en && (w_ld_idx == IW'(gi));
            pdw_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl[gi]),
                .i_nbr       (w_nbr),
                .i_load_data (w_ld_data),
                .o_entry     (w_entry[gi])
            );
        end
    endgenerate

    assign w_head      = w_entry[0];
    assign w_age       = r_now - w_head.stamp;
    assign w_live      = w_age < r_expiry;
    assign w_match     = w_head.pkt_id == r_id;
    assign w_keep      = (r_kind == KIND_QUERY) || w_live;
    assign w_ptr_dec   = r_ptr - CW'(1);
    assign w_slot_free = !r_ovalid || i_m_tready;
    assign o_s_tready  = r_state == ST_IDLE;
    assign w_s_acc     = i_s_tvalid && o_s_tready;
    assign w_add       = (r_kind == KIND_CHECK) && !r_hit;
    assign w_new_cnt   = (w_add && (r_kept != CW'(ENTRIES))) ? r_kept + CW'(1) : r_kept;
    assign w_cnt_ext   = (CW + 6)'(w_new_cnt);

    always_comb begin
        n_state   = r_state;
        w_scan    = 1'b0;
        w_ld_en   = 1'b0;
        w_ld_idx  = '0;
        w_ld_data = '{stamp: r_now, pkt_id: r_id};
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = (r_cnt == '0) ? ST_UPDATE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                w_scan    = 1'b1;
                w_ld_en   = w_keep;
                w_ld_idx  = w_ptr_dec[IW-1:0];
                w_ld_data = w_head;
                if (r_left == CW'(1)) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (w_slot_free) begin
                    n_state  = ST_IDLE;
                    w_ld_en  = w_add;
                    w_ld_idx = (r_kept == CW'(ENTRIES)) ? r_min_idx : r_kept[IW-1:0];
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_expiry <= EXPIRY_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_expiry <= i_cfg_wdata;
            end
            if ((r_state == ST_UPDATE) && w_slot_free) begin
                r_ovalid <= 1'b1;
                r_cnt    <= w_new_cnt;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_kind <= i_s_tuser;
            r_id   <= i_s_tdata[31:0];
            r_now  <= i_s_tdata[63:32];
            r_left <= r_cnt;
            r_ptr  <= r_cnt;
            r_kept <= '0;
            r_hit  <= 1'b0;
        end else if (r_state == ST_SCAN) begin
            r_left <= r_left - CW'(1);
            if (!w_keep) begin
                r_ptr <= w_ptr_dec;
            end
            if (w_keep) begin
                r_kept <= r_kept + CW'(1);
                if ((r_kept == '0) || (w_head.stamp < r_min_stamp)) begin
                    r_min_stamp <= w_head.stamp;
                    r_min_idx   <= r_kept[IW-1:0];
                end
            end
            if (w_match && w_live) begin
                r_hit <= 1'b1;
            end
        end
        if ((r_state == ST_UPDATE) && w_slot_free) begin
            r_ohit   <= r_hit;
            r_ocount <= w_cnt_ext[COUNT_W-1:0];
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {1'b0, r_ocount, r_ohit};

    `PDW_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(ENTRIES))
    `PDW_ASSERT_IMP(a_scan_ptr, i_clk, i_rst_n, r_state == ST_SCAN, (r_ptr >= r_left) && (r_left != '0))
    `PDW_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_s_acc, r_state != ST_IDLE)
    `PDW_ASSERT_NEXT(a_result_load, i_clk, i_rst_n, (r_state == ST_UPDATE) && w_slot_free, r_ovalid && (r_state == ST_IDLE))

endmodule
`default_nettype wire

/* tb/tb_packet_dedup_window_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the packet dedup window: directed table, then random phases in four pacing modes.
module tb_packet_dedup_window_unit;
    import pdw_pkg::*;

    localparam int unsigned DEPTH        = 32;
    localparam int unsigned POOL_SIZE    = 40;
    localparam int unsigned DRILL_ROWS   = 21;
    localparam int unsigned PHASES       = 8;
    localparam int unsigned QUIET_LIMIT  = 2000;
    localparam int unsigned REPORT_LIMIT = 10;

    typedef enum logic [1:0] {
        PACE_FULL,
        PACE_SEND_IDLE,
        PACE_RECV_STALL,
        PACE_BOTH
    } pace_t;

    typedef struct packed {
        logic               kind;
        logic [ID_W-1:0]    pkt_id;
        logic [STAMP_W-1:0] time_now;
    } pkt_in_t;

    typedef struct packed {
        logic               hit;
        logic [COUNT_W-1:0] count;
    } verdict_t;

    typedef struct packed {
        pkt_in_t  item;
        logic     pinned;
        verdict_t want;
    } drill_row_t;

    localparam logic [STAMP_W-1:0] PHASE_EXPIRY [PHASES] = '{
        EXPIRY_RESET, 32'hFFFF_FFFF, 32'd1, 32'd1000,
        32'd0, 32'h8000_0000, 32'd500, 32'd30000
    };
    localparam pace_t PHASE_PACE [PHASES] = '{
        PACE_FULL, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH,
        PACE_FULL, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH
    };
    localparam int unsigned PHASE_ITEMS [PHASES] = '{200, 200, 170, 180, 60, 200, 170, 250};

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;   // [31:0] pkt_id, [63:32] time_now
    logic        s_tuser   = 1'b0; // [0] kind
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;          // [0] hit, [6:1] entry_count, [7] zero

    t_entry             window_list [DEPTH];
    int unsigned        window_fill   = 0;
    logic [STAMP_W-1:0] window_expiry = EXPIRY_RESET;
    logic [ID_W-1:0]    id_pool [POOL_SIZE];
    verdict_t           verdicts [$];

    logic        send_idles   = 1'b0;
    logic        recv_stalls  = 1'b0;
    int unsigned idle_pct     = 79;
    int unsigned errors       = 0;
    int unsigned items_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned query_total  = 0;
    int unsigned hit_total    = 0;
    int unsigned evict_total  = 0;
    int unsigned peak_fill    = 0;
    int unsigned quiet_cycles = 0;

    packet_dedup_window_unit #(
        .ENTRIES(DEPTH)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    always #10 clk = ~clk;

    function automatic void note_error(input string what);
        errors++;
        if (errors <= REPORT_LIMIT) $display("ERROR: %s", what);
    endfunction

    function automatic logic is_live(input logic [STAMP_W-1:0] stamp,
                                     input logic [STAMP_W-1:0] now);
        logic [STAMP_W-1:0] age;
        age = now - stamp;
        return age < window_expiry;
    endfunction

    // Purge, look up and insert exactly as the window does for one packet.
    function automatic verdict_t screen_packet(input pkt_in_t it);
        verdict_t    v;
        int unsigned i;
        int unsigned keep;
        int unsigned oldest;
        v.hit = 1'b0;
        if (it.kind == KIND_QUERY) begin
            query_total++;
            for (i = 0; i < window_fill; i++)
                if (window_list[i].pkt_id == it.pkt_id
                    && is_live(window_list[i].stamp, it.time_now))
                    v.hit = 1'b1;
        end else begin
            keep = 0;
            for (i = 0; i < window_fill; i++) begin
                if (is_live(window_list[i].stamp, it.time_now)) begin
                    window_list[keep] = window_list[i];
                    keep++;
                end
            end
            window_fill = keep;
            for (i = 0; i < window_fill; i++)
                if (window_list[i].pkt_id == it.pkt_id) v.hit = 1'b1;
            if (!v.hit) begin
                if (window_fill < DEPTH) begin
                    window_list[window_fill] = '{stamp: it.time_now, pkt_id: it.pkt_id};
                    window_fill++;
                end else begin
                    oldest = 0;
                    for (i = 1; i < DEPTH; i++)
                        if (window_list[i].stamp < window_list[oldest].stamp) oldest = i;
                    window_list[oldest] = '{stamp: it.time_now, pkt_id: it.pkt_id};
                    evict_total++;
                end
            end
        end
        if (v.hit) hit_total++;
        if (window_fill > peak_fill) peak_fill = window_fill;
        v.count = COUNT_W'(window_fill);
        return v;
    endfunction

    function automatic drill_row_t drill_row(input logic kind, input logic [31:0] id,
                                             input logic [31:0] now, input logic pinned,
                                             input logic hit, input int unsigned count);
        drill_row_t r;
        r.item   = '{kind: kind, pkt_id: id, time_now: now};
        r.pinned = pinned;
        r.want   = '{hit: hit, count: COUNT_W'(count)};
        return r;
    endfunction

    function automatic logic [STAMP_W-1:0] next_stamp(input logic [STAMP_W-1:0] t);
        logic [STAMP_W-1:0] span;
        int unsigned        r;
        span = window_expiry >> 6;
        if (span > 5000) span = 5000;
        if (span == 0) span = 1;
        r = $urandom_range(99);
        if (r < 10) return t;
        if (r < 75) return t + $urandom_range(span);
        if (r < 87) return t + $urandom_range(window_expiry);
        if (r < 94) return t - $urandom_range(span);
        return $urandom();
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(99) < 80) return id_pool[$urandom_range(POOL_SIZE - 1)];
        return $urandom();
    endfunction

    function automatic void set_pace(input pace_t pace);
        send_idles  = (pace == PACE_SEND_IDLE) || (pace == PACE_BOTH);
        recv_stalls = (pace == PACE_RECV_STALL) || (pace == PACE_BOTH);
        idle_pct    = (pace == PACE_BOTH) ? 23 : 79;
    endfunction

    task automatic send_item(input pkt_in_t it, input logic pinned, input verdict_t want);
        verdict_t v;
        @(negedge clk);
        while (send_idles && $urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {it.time_now, it.pkt_id};
        s_tuser  <= it.kind;
        do @(posedge clk); while (!s_tready);
        v = screen_packet(it);
        verdicts.push_back(pinned ? want : v);
        items_sent++;
    endtask

    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (verdicts.size() != 0) @(posedge clk);
        repeat (DEPTH + 4) @(posedge clk);
    endtask

    task automatic write_expiry(input logic [STAMP_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        window_expiry = value;
    endtask

    always @(negedge clk) m_tready <= !recv_stalls || ($urandom_range(99) >= idle_pct);

    always @(posedge clk) begin
        verdict_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (verdicts.size() == 0) begin
                note_error($sformatf("result %0d hit=%0b count=%0d arrived with nothing pending",
                                     results_seen, m_tdata[0], m_tdata[6:1]));
            end else begin
                want = verdicts.pop_front();
                if (m_tdata[0] !== want.hit || m_tdata[6:1] !== want.count
                    || m_tdata[7] !== 1'b0)
                    note_error($sformatf(
                        "result %0d: expected hit=%0b count=%0d pad=0, got hit=%0b count=%0d pad=%0b",
                        results_seen, want.hit, want.count, m_tdata[0], m_tdata[6:1], m_tdata[7]));
            end
            results_seen++;
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("tb_packet_dedup_window_unit failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        drill_row_t         drill [DRILL_ROWS];
        pkt_in_t            it;
        logic [STAMP_W-1:0] now_ms;
        int unsigned        p;
        int unsigned        n;

        drill = '{
            drill_row(KIND_QUERY, 32'h0000_0000, 32'd0,         1'b1, 1'b0, 0),
            drill_row(KIND_CHECK, 32'h0000_0000, 32'd0,         1'b1, 1'b0, 1),
            drill_row(KIND_CHECK, 32'h0000_0000, 32'd100,       1'b1, 1'b1, 1),
            drill_row(KIND_QUERY, 32'h0000_0000, 32'd29999,     1'b1, 1'b1, 1),
            drill_row(KIND_QUERY, 32'h0000_0000, 32'd30000,     1'b1, 1'b0, 1),
            drill_row(KIND_QUERY, 32'hFFFF_FFFF, 32'd0,         1'b1, 1'b0, 1),
            drill_row(KIND_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 1),
            drill_row(KIND_CHECK, 32'h1234_5678, 32'd5,         1'b1, 1'b0, 2),
            drill_row(KIND_QUERY, 32'hFFFF_FFFF, 32'd6,         1'b1, 1'b1, 2),
            drill_row(KIND_CHECK, 32'hA5A5_A5A5, 32'd0,         1'b1, 1'b0, 2),
            drill_row(KIND_QUERY, 32'h1234_5678, 32'd0,         1'b1, 1'b0, 2),
            drill_row(KIND_CHECK, 32'h5A5A_5A5A, 32'd0,         1'b0, 1'b0, 0),
            drill_row(KIND_CHECK, 32'hFFFF_FFFF, 32'd29999,     1'b0, 1'b0, 0),
            drill_row(KIND_CHECK, 32'hA5A5_A5A5, 32'd29999,     1'b0, 1'b0, 0),
            drill_row(KIND_QUERY, 32'h5A5A_5A5A, 32'd30000,     1'b0, 1'b0, 0),
            drill_row(KIND_CHECK, 32'h0000_0001, 32'd30000,     1'b0, 1'b0, 0),
            drill_row(KIND_QUERY, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0, 0),
            drill_row(KIND_CHECK, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 0),
            drill_row(KIND_CHECK, 32'h1111_1111, 32'd30000,     1'b0, 1'b0, 0),
            drill_row(KIND_CHECK, 32'h2222_2222, 32'd30000,     1'b0, 1'b0, 0),
            drill_row(KIND_CHECK, 32'h1111_1111, 32'd30000,     1'b0, 1'b0, 0)
        };
        id_pool[0] = 32'h0000_0000;
        id_pool[1] = 32'hFFFF_FFFF;
        for (n = 2; n < POOL_SIZE; n++) id_pool[n] = $urandom();
        now_ms = 32'd40000;

        set_pace(PACE_FULL);
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (n = 0; n < DRILL_ROWS; n++)
            send_item(drill[n].item, drill[n].pinned, drill[n].want);

        for (p = 0; p < PHASES; p++) begin
            settle();
            if (p != 0) write_expiry(PHASE_EXPIRY[p]);
            set_pace(PHASE_PACE[p]);
            for (n = 0; n < PHASE_ITEMS[p]; n++) begin
                it.kind     = ($urandom_range(99) < 25) ? KIND_QUERY : KIND_CHECK;
                it.pkt_id   = pick_id();
                now_ms      = next_stamp(now_ms);
                it.time_now = now_ms;
                send_item(it, 1'b0, '0);
            end
        end
        settle();

        if (verdicts.size() != 0)
            note_error($sformatf("%0d results never arrived", verdicts.size()));
        $display("Sent %0d packets (%0d queries) across %0d expiry settings and four pacing modes.",
                 items_sent, query_total, PHASES);
        $display("Saw %0d hits, %0d evictions from a full window, peak fill %0d of %0d, %0d errors.",
                 hit_total, evict_total, peak_fill, DEPTH, errors);
        if (errors == 0) begin
            $display("tb_packet_dedup_window_unit passed");
        end else begin
            $display("tb_packet_dedup_window_unit failed");
        end
        $finish;
    end

endmodule
